// ----- rtl/sosf_pkg.sv -----
// ----------------------------------------------------------------------------
// sosf_pkg
// Shared types and constants of the sine oscillator with sync and feedback.
// ----------------------------------------------------------------------------
package sosf_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INCREMENT_SCALE = 2'd0,
      CSR_OCTAVE_SPAN     = 2'd1,
      CSR_FEEDBACK_GAIN   = 2'd2
   } csr_index_type;

   localparam logic [23:0] INCREMENT_SCALE_RESET = 24'd89478;
   localparam logic [4:0]  OCTAVE_SPAN_RESET     = 5'd10;
   localparam logic [15:0] FEEDBACK_GAIN_RESET   = 16'd11796;

   localparam logic [4:0]  SPAN_MIN = 5'd1;
   localparam logic [4:0]  SPAN_MAX = 5'd16;

   // shared multiplier: signed operands, wide enough for 32-bit unsigned values
   localparam int MUL_W = 33;

   // exp2 of the fractional octave: 2^f = e^(f*ln2), Q30
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
   localparam logic [3:0]  EXP_TERMS = 4'd10;
   localparam logic [6:0]  SHIFT_BASE = 7'd38;

   // item payloads
   typedef struct packed {
      logic signed [15:0] pitch;
      logic signed [15:0] sync_sample;
      logic signed [23:0] fundamental;
      logic        [15:0] phase_offset;
      logic signed [15:0] feedback_amount;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] sample;
   } rsp_payload_type;

   // floor(2^32 / n); the one-step correction after the multiply makes the
   // quotient exact for numerators below 2^30 (n = 1 uses 2^32 - 1 likewise)
   function automatic logic [31:0] recip_of(input logic [3:0] n);
      logic [31:0] r;
      unique case (n)
         4'd1:    r = 32'hFFFF_FFFF;
         4'd2:    r = 32'h8000_0000;
         4'd3:    r = 32'h5555_5555;
         4'd4:    r = 32'h4000_0000;
         4'd5:    r = 32'h3333_3333;
         4'd6:    r = 32'h2AAA_AAAA;
         4'd7:    r = 32'h2492_4924;
         4'd8:    r = 32'h2000_0000;
         4'd9:    r = 32'h1C71_C71C;
         4'd10:   r = 32'h1999_9999;
         default: r = 32'h0000_0000;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/sosf_stream_if.sv -----
// ----------------------------------------------------------------------------
// sosf_stream_if
// Valid/ready item channel with a typed payload.
// ----------------------------------------------------------------------------
interface sosf_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/sosf_mult.sv -----
// ----------------------------------------------------------------------------
// sosf_mult
// Shared signed multiplier with a registered product, loaded when enabled.
// ----------------------------------------------------------------------------
module sosf_mult (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [sosf_pkg::MUL_W-1:0]    a,
   input  logic signed [sosf_pkg::MUL_W-1:0]    b,
   output logic signed [2*sosf_pkg::MUL_W-1:0]  product_ff
);
   import sosf_pkg::*;

   logic signed [2*MUL_W-1:0] product_in;

   assign product_in = a * b;

   always_ff @(posedge clock) begin
      if (en) begin
         product_ff <= product_in;
      end
   end

endmodule

// ----- rtl/sosf_sine_rom.sv -----
// ----------------------------------------------------------------------------
// sosf_sine_rom
// Full-cycle Q1.15 sine table with one guard entry, registered read.
// ----------------------------------------------------------------------------
module sosf_sine_rom #(
   parameter int TABLE_BITS = 10
) (
   input  logic                      clock,
   input  logic [TABLE_BITS:0]       addr,
   output logic signed [15:0]        data_ff
);

   localparam int unsigned TBL_N = 1 << TABLE_BITS;
   localparam longint unsigned QTR = TBL_N / 4;
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam longint unsigned TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                    64'd110, 64'd156};

   typedef logic signed [15:0] rom_word_type;
   typedef rom_word_type rom_array_type [0:TBL_N];

   // sin(pi/2 * r/QTR) scaled to 32767, odd Taylor series in Q30
   function automatic rom_word_type quarter_sine(input longint unsigned r);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          val;
      x    = (PI_HALF_Q30 * r) / QTR;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n];
         if ((n % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      val = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
      if (val > 32767) begin
         val = 32767;
      end
      return rom_word_type'(val);
   endfunction

   function automatic rom_array_type build_rom();
      rom_array_type   t;
      longint unsigned quad;
      longint unsigned r;
      for (int unsigned k = 0; k < TBL_N; k++) begin
         quad = k / QTR;
         r    = k % QTR;
         unique case (quad)
            0:       t[k] = quarter_sine(r);
            1:       t[k] = quarter_sine(QTR - r);
            2:       t[k] = -quarter_sine(r);
            default: t[k] = -quarter_sine(QTR - r);
         endcase
      end
      t[TBL_N] = t[0];
      return t;
   endfunction

   localparam rom_array_type SINE_ROM = build_rom();

   always_ff @(posedge clock) begin
      data_ff <= SINE_ROM[addr];
   end

endmodule

// ----- rtl/sine_oscillator_sync_feedback.sv -----
// ----------------------------------------------------------------------------
// sine_oscillator_sync_feedback
// Phase-accumulator sine oscillator with exponential pitch, hard sync,
// phase modulation and delayed self feedback.
// ----------------------------------------------------------------------------
// The ten-term series for the fractional octave runs a multiply, a multiply by the reciprocal of the
//   term index and a correction step for each term, the first two in the multiplier.
// The request side is ready only between items; a waiting result is held.
// Reset (synchronous, active high) restores register defaults and clears the
//   phase and the feedback history at once; there is no clearing pass.
module sine_oscillator_sync_feedback #(
   parameter int FEEDBACK_DELAY  = 4,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [sosf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sosf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   sosf_stream_if.sink                        req_stream,
   sosf_stream_if.source                      rsp_stream
);
   import sosf_pkg::*;

   localparam int ADDR_W = SINE_TABLE_BITS + 1;

   typedef enum logic [18:0] {
      ST_IDLE      = 19'h00001,
      ST_SPAN      = 19'h00002,
      ST_FRAC      = 19'h00004,
      ST_LN2       = 19'h00008,
      ST_INIT      = 19'h00010,
      ST_EXP_MUL   = 19'h00020,
      ST_EXP_RCP   = 19'h00040,
      ST_EXP_FIX   = 19'h00080,
      ST_INC_LO    = 19'h00100,
      ST_INC_HI    = 19'h00200,
      ST_INC_ADD   = 19'h00400,
      ST_INC_SHIFT = 19'h00800,
      ST_PHASE     = 19'h01000,
      ST_FB        = 19'h02000,
      ST_THETA     = 19'h04000,
      ST_RD_A      = 19'h08000,
      ST_RD_B      = 19'h10000,
      ST_INTERP    = 19'h20000,
      ST_OUT       = 19'h40000
   } state_type;

   // control
   state_type         state_ff, state_in;
   logic [23:0]       inc_scale_ff, inc_scale_in;
   logic [4:0]        span_ff, span_in;
   logic [15:0]       gain_ff, gain_in;
   logic [31:0]       phase_ff, phase_in;
   logic signed [15:0] hist_ff [FEEDBACK_DELAY];
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath
   req_payload_type   item_ff, item_in;
   logic [5:0]        shift_ff, shift_in;
   logic [14:0]       fr_ff, fr_in;
   logic [46:0]       mag_ff, mag_in;
   logic [29:0]       y_ff, y_in;
   logic [30:0]       term_ff, term_in;
   logic [30:0]       sum_ff, sum_in;
   logic [29:0]       q_ff, q_in;
   logic [3:0]        n_ff, n_in;
   logic [62:0]       p0_ff, p0_in;
   logic [77:0]       wide_ff, wide_in;
   logic [31:0]       inc_ff, inc_in;
   logic [31:0]       theta_ff, theta_in;
   logic signed [15:0] a_ff, a_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   // shared units
   logic                      mul_en;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_p;
   logic [ADDR_W-1:0]         rom_addr;
   logic signed [15:0]        rom_data;

   // helpers
   logic [4:0]        span_eff;
   logic [23:0]       fund_mag;
   logic [6:0]        shift_calc;
   logic [29:0]       est;
   logic [33:0]       est_n;
   logic [33:0]       rem;
   logic [30:0]       term_fix;
   logic              sync_pos;
   logic [SINE_TABLE_BITS-1:0] idx;
   logic [15:0]       frac16;
   logic signed [16:0] diff;
   logic signed [15:0] y_out;
   logic              load_out;

   sosf_mult u_mult (
      .clock      (clock),
      .en         (mul_en),
      .a          (mul_a),
      .b          (mul_b),
      .product_ff (mul_p)
   );

   sosf_sine_rom #(
      .TABLE_BITS (SINE_TABLE_BITS)
   ) u_rom (
      .clock   (clock),
      .addr    (rom_addr),
      .data_ff (rom_data)
   );

   assign req_stream.ready   = (state_ff == ST_IDLE);
   assign rsp_stream.valid   = rsp_valid_ff;
   assign rsp_stream.payload = rsp_data_ff;

   assign span_eff = (span_ff < SPAN_MIN) ? SPAN_MIN :
                     (span_ff > SPAN_MAX) ? SPAN_MAX : span_ff;
   assign fund_mag = item_ff.fundamental[23] ? (~item_ff.fundamental + 24'd1)
                                             : item_ff.fundamental;
   // right shift of the full product is 38 minus the integer octave
   assign shift_calc = SHIFT_BASE - {mul_p[20], mul_p[20:15]};

   // quotient estimate is exact or one low
   assign est      = mul_p[61:32];
   assign est_n    = 34'(est) * 34'(n_ff);
   assign rem      = 34'(q_ff) - est_n;
   assign term_fix = (rem >= 34'(n_ff)) ? (31'(est) + 31'd1) : 31'(est);

   assign sync_pos = !item_ff.sync_sample[15] && (item_ff.sync_sample != 16'sd0);
   assign idx      = theta_ff[31 -: SINE_TABLE_BITS];
   assign frac16   = theta_ff[31-SINE_TABLE_BITS -: 16];
   assign diff     = {rom_data[15], rom_data} - {a_ff[15], a_ff};
   assign y_out    = a_ff + mul_p[31:16];
   assign rom_addr = ADDR_W'({1'b0, idx}) + ADDR_W'(state_ff == ST_RD_B);
   assign load_out = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_stream.ready);

   always_comb begin
      state_in     = state_ff;
      inc_scale_in = inc_scale_ff;
      span_in      = span_ff;
      gain_in      = gain_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_stream.ready;
      item_in      = item_ff;
      shift_in     = shift_ff;
      fr_in        = fr_ff;
      mag_in       = mag_ff;
      y_in         = y_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      q_in         = q_ff;
      n_in         = n_ff;
      p0_in        = p0_ff;
      wide_in      = wide_ff;
      inc_in       = inc_ff;
      theta_in     = theta_ff;
      a_in         = a_ff;
      rsp_data_in  = rsp_data_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_INCREMENT_SCALE: inc_scale_in = csr_wdata[23:0];
            CSR_OCTAVE_SPAN:     span_in      = csr_wdata[4:0];
            CSR_FEEDBACK_GAIN:   gain_in      = csr_wdata[15:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_stream.valid) begin
               item_in  = req_stream.payload;
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            mul_en   = 1'b1;
            mul_a    = {{17{item_ff.pitch[15]}}, item_ff.pitch};
            mul_b    = MUL_W'(span_eff);
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            shift_in = shift_calc[5:0];
            fr_in    = mul_p[14:0];
            mul_en   = 1'b1;
            mul_a    = MUL_W'(fund_mag);
            mul_b    = MUL_W'(inc_scale_ff);
            state_in = ST_LN2;
         end
         ST_LN2: begin
            mag_in   = mul_p[46:0];
            mul_en   = 1'b1;
            mul_a    = MUL_W'(fr_ff);
            mul_b    = MUL_W'(LN2_Q30);
            state_in = ST_INIT;
         end
         ST_INIT: begin
            y_in     = mul_p[44:15];
            term_in  = Q30_ONE;
            sum_in   = Q30_ONE;
            n_in     = 4'd1;
            state_in = ST_EXP_MUL;
         end
         ST_EXP_MUL: begin
            mul_en   = 1'b1;
            mul_a    = MUL_W'(term_ff);
            mul_b    = MUL_W'(y_ff);
            state_in = ST_EXP_RCP;
         end
         ST_EXP_RCP: begin
            q_in     = mul_p[59:30];
            mul_en   = 1'b1;
            mul_a    = MUL_W'(mul_p[59:30]);
            mul_b    = MUL_W'(recip_of(n_ff));
            state_in = ST_EXP_FIX;
         end
         ST_EXP_FIX: begin
            term_in = term_fix;
            sum_in  = sum_ff + term_fix;
            if (n_ff == EXP_TERMS) begin
               state_in = ST_INC_LO;
            end else begin
               n_in     = n_ff + 4'd1;
               state_in = ST_EXP_MUL;
            end
         end
         ST_INC_LO: begin
            mul_en   = 1'b1;
            mul_a    = MUL_W'(mag_ff[31:0]);
            mul_b    = MUL_W'(sum_ff);
            state_in = ST_INC_HI;
         end
         ST_INC_HI: begin
            p0_in    = mul_p[62:0];
            mul_en   = 1'b1;
            mul_a    = MUL_W'(mag_ff[46:32]);
            mul_b    = MUL_W'(sum_ff);
            state_in = ST_INC_ADD;
         end
         ST_INC_ADD: begin
            wide_in  = 78'(p0_ff) + {mul_p[45:0], 32'h0};
            state_in = ST_INC_SHIFT;
         end
         ST_INC_SHIFT: begin
            inc_in   = 32'(wide_ff >> shift_ff);
            state_in = ST_PHASE;
         end
         ST_PHASE: begin
            // sync wins over the increment just added
            if (sync_pos) begin
               phase_in = 32'h0;
            end else if (item_ff.fundamental[23]) begin
               phase_in = phase_ff - inc_ff;
            end else begin
               phase_in = phase_ff + inc_ff;
            end
            mul_en   = 1'b1;
            mul_a    = {{17{item_ff.feedback_amount[15]}}, item_ff.feedback_amount};
            mul_b    = MUL_W'(gain_ff);
            state_in = ST_FB;
         end
         ST_FB: begin
            mul_en   = 1'b1;
            mul_a    = mul_p[MUL_W-1:0];
            mul_b    = {{17{hist_ff[FEEDBACK_DELAY-1][15]}}, hist_ff[FEEDBACK_DELAY-1]};
            state_in = ST_THETA;
         end
         ST_THETA: begin
            // feedback term is the product floored by 2^14, modulo 2^32
            theta_in = phase_ff + {item_ff.phase_offset, 16'h0} + mul_p[45:14];
            state_in = ST_RD_A;
         end
         ST_RD_A: begin
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            a_in     = rom_data;
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            mul_en   = 1'b1;
            mul_a    = {{16{diff[16]}}, diff};
            mul_b    = MUL_W'(frac16);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (load_out) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.sample = y_out;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inc_scale_ff <= INCREMENT_SCALE_RESET;
         span_ff      <= OCTAVE_SPAN_RESET;
         gain_ff      <= FEEDBACK_GAIN_RESET;
         phase_ff     <= 32'h0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < FEEDBACK_DELAY; i++) begin
            hist_ff[i] <= 16'sd0;
         end
      end else begin
         state_ff     <= state_in;
         inc_scale_ff <= inc_scale_in;
         span_ff      <= span_in;
         gain_ff      <= gain_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_out) begin
            hist_ff[0] <= y_out;
            for (int i = 1; i < FEEDBACK_DELAY; i++) begin
               hist_ff[i] <= hist_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      shift_ff    <= shift_in;
      fr_ff       <= fr_in;
      mag_ff      <= mag_in;
      y_ff        <= y_in;
      term_ff     <= term_in;
      sum_ff      <= sum_in;
      q_ff        <= q_in;
      n_ff        <= n_in;
      p0_ff       <= p0_in;
      wide_ff     <= wide_in;
      inc_ff      <= inc_in;
      theta_ff    <= theta_in;
      a_ff        <= a_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_valid_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

   a_phase_only_in_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_PHASE) |=> $stable(phase_ff))
      else $error("phase moved outside the phase update");

   a_term_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXP_FIX) |-> (n_ff >= 4'd1 && n_ff <= EXP_TERMS))
      else $error("series term counter out of range");

   a_history_on_load: assert property (@(posedge clock) disable iff (reset)
      !load_out |=> $stable(hist_ff[0]))
      else $error("feedback history shifted without a result");
`endif

endmodule
